// ----- rtl/ufu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ufu_pkg;

  // Request types (bmRequestType)
  localparam logic [7:0] RT_OUT = 8'h21;
  localparam logic [7:0] RT_IN  = 8'hA1;

  // Request codes (bRequest)
  localparam logic [7:0] RQ_SET_CUR = 8'h01;
  localparam logic [7:0] RQ_GET_CUR = 8'h81;
  localparam logic [7:0] RQ_GET_MIN = 8'h82;
  localparam logic [7:0] RQ_GET_MAX = 8'h83;
  localparam logic [7:0] RQ_GET_RES = 8'h84;

  // Control selectors
  localparam logic [7:0] SEL_MUTE   = 8'h01;
  localparam logic [7:0] SEL_VOLUME = 8'h02;

  // Channel numbers
  localparam logic [7:0] CH_MASTER = 8'h00;
  localparam logic [7:0] CH_LEFT   = 8'h01;
  localparam logic [7:0] CH_RIGHT  = 8'h02;

  // Item opcodes
  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Reply lengths
  localparam logic [1:0] LEN_NONE   = 2'd0;
  localparam logic [1:0] LEN_MUTE   = 2'd1;
  localparam logic [1:0] LEN_VOLUME = 2'd2;

  // Expected wLength for SET_CUR
  localparam logic [15:0] WLEN_MUTE   = 16'd1;
  localparam logic [15:0] WLEN_VOLUME = 16'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_RES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_DFLT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_MUTE = 3'd5;

  // Configuration reset values
  localparam logic [7:0]         UNIT_ID_RST  = 8'd2;
  localparam logic signed [15:0] VOL_MIN_RST  = 16'sh8000;
  localparam logic signed [15:0] VOL_MAX_RST  = 16'sh0000;
  localparam logic signed [15:0] VOL_RES_RST  = 16'sh0100;
  localparam logic signed [15:0] VOL_DFLT_RST = 16'sh0000;
  localparam logic signed [15:0] VOL_MUTE_RST = 16'sh8000;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic [15:0] payload;
  } req_t;

  typedef struct packed {
    logic               stall_res;
    logic [1:0]         reply_length;
    logic [15:0]        reply_data;
    logic               apply_valid;
    logic signed [15:0] applied_left;
    logic signed [15:0] applied_right;
  } rsp_t;

  // Configuration registers handed to the request core
  typedef struct packed {
    logic [7:0]         unit_id;
    logic signed [15:0] vol_min;
    logic signed [15:0] vol_max;
    logic signed [15:0] vol_res;
    logic signed [15:0] vol_dflt;
    logic signed [15:0] vol_mute;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/usb_audio_feature_unit_ctrl.sv -----
// Path: a taken request sits in the input register, then moves into the result
// register once that register is free, and leaves from there when taken.
// Throughput: one request per cycle while results are taken.
// Reset (rst, synchronous): both stages empty, mute on, channel and applied
// volumes zero, configuration registers at their documented defaults.
`timescale 1ns / 1ps
`default_nettype none

module usb_audio_feature_unit_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire ufu_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output ufu_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_we,
  input  wire logic [ufu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                     cfg_wdata
);

  ufu_pkg::cfg_t cfg;
  ufu_pkg::req_t item;
  ufu_pkg::rsp_t result;
  logic          item_valid;
  logic          advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_id  <= ufu_pkg::UNIT_ID_RST;
      cfg.vol_min  <= ufu_pkg::VOL_MIN_RST;
      cfg.vol_max  <= ufu_pkg::VOL_MAX_RST;
      cfg.vol_res  <= ufu_pkg::VOL_RES_RST;
      cfg.vol_dflt <= ufu_pkg::VOL_DFLT_RST;
      cfg.vol_mute <= ufu_pkg::VOL_MUTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ufu_pkg::CFG_UNIT_ID:  cfg.unit_id  <= cfg_wdata[7:0];
        ufu_pkg::CFG_VOL_MIN:  cfg.vol_min  <= $signed(cfg_wdata);
        ufu_pkg::CFG_VOL_MAX:  cfg.vol_max  <= $signed(cfg_wdata);
        ufu_pkg::CFG_VOL_RES:  cfg.vol_res  <= $signed(cfg_wdata);
        ufu_pkg::CFG_VOL_DFLT: cfg.vol_dflt <= $signed(cfg_wdata);
        ufu_pkg::CFG_VOL_MUTE: cfg.vol_mute <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Item moves into the result register when that register is free
  assign advance = item_valid && (!rsp_valid || rsp_ready);

  ufu_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ufu_req_core u_req_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  // A stalled request carries no reply and no volume update
  a_stall_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.stall_res |->
      rsp.reply_length == ufu_pkg::LEN_NONE && rsp.reply_data == 16'h0000 &&
      !rsp.apply_valid)
    else $error("stalled result carries reply or update");

  // A volume update never comes with IN reply data
  a_apply_no_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.apply_valid |-> rsp.reply_length == ufu_pkg::LEN_NONE)
    else $error("update with reply data");

  // Reply length is only ever none, one or two bytes
  a_reply_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.reply_length != 2'd3)
    else $error("illegal reply length");

  // No result appears in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- rtl/ufu_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one request until the core takes it.
module ufu_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ufu_pkg::req_t req,
  input  wire logic          take,
  output logic               item_valid,
  output ufu_pkg::req_t      item
);

  // Free when empty or when the held item leaves this cycle
  assign req_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ufu_req_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request decode, control state and applied volume pair.
module ufu_req_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          commit,
  input  wire ufu_pkg::req_t item,
  input  wire ufu_pkg::cfg_t cfg,
  output ufu_pkg::rsp_t      result
);

  logic               muted;
  logic signed [15:0] chan_left;
  logic signed [15:0] chan_right;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;

  logic               muted_next;
  logic signed [15:0] chan_left_next;
  logic signed [15:0] chan_right_next;
  logic signed [15:0] out_left_next;
  logic signed [15:0] out_right_next;

  logic [7:0] sel;
  logic [7:0] ch;
  logic       ch_vol;
  logic       unit_ok;
  logic       is_get_vol;
  logic       drive;
  logic       stall;
  logic [1:0] rlen;
  logic [15:0] rdata;

  assign sel     = item.value_word[15:8];
  assign ch      = item.value_word[7:0];
  assign ch_vol  = (ch == ufu_pkg::CH_LEFT) || (ch == ufu_pkg::CH_RIGHT);
  assign unit_ok = (item.index_word == {cfg.unit_id, 8'h00});
  assign is_get_vol = (item.request_code == ufu_pkg::RQ_GET_CUR) ||
                      (item.request_code == ufu_pkg::RQ_GET_MIN) ||
                      (item.request_code == ufu_pkg::RQ_GET_MAX) ||
                      (item.request_code == ufu_pkg::RQ_GET_RES);

  // Decode and next state
  always_comb begin
    muted_next      = muted;
    chan_left_next  = chan_left;
    chan_right_next = chan_right;
    drive           = 1'b0;
    stall           = 1'b0;
    rlen            = ufu_pkg::LEN_NONE;
    rdata           = 16'h0000;

    if (item.opcode == ufu_pkg::OP_RESET) begin
      chan_left_next  = cfg.vol_dflt;
      chan_right_next = cfg.vol_dflt;
      muted_next      = 1'b1;
      drive           = 1'b1;
    end else if (!unit_ok) begin
      stall = 1'b1;
    end else if (item.request_type == ufu_pkg::RT_OUT) begin
      if (sel == ufu_pkg::SEL_MUTE && item.request_code == ufu_pkg::RQ_SET_CUR &&
          ch == ufu_pkg::CH_MASTER && item.length_word == ufu_pkg::WLEN_MUTE) begin
        muted_next = (item.payload[7:0] != 8'h00);
        drive      = 1'b1;
      end else if (sel == ufu_pkg::SEL_VOLUME &&
                   item.request_code == ufu_pkg::RQ_SET_CUR &&
                   ch_vol && item.length_word == ufu_pkg::WLEN_VOLUME) begin
        if (ch == ufu_pkg::CH_LEFT) begin
          chan_left_next = $signed(item.payload);
        end else begin
          chan_right_next = $signed(item.payload);
        end
        drive = !muted;
      end else begin
        stall = 1'b1;
      end
    end else if (item.request_type == ufu_pkg::RT_IN) begin
      if (sel == ufu_pkg::SEL_MUTE && item.request_code == ufu_pkg::RQ_GET_CUR &&
          ch == ufu_pkg::CH_MASTER) begin
        rlen  = ufu_pkg::LEN_MUTE;
        rdata = {15'h0000, muted};
      end else if (sel == ufu_pkg::SEL_VOLUME && ch_vol && is_get_vol) begin
        rlen = ufu_pkg::LEN_VOLUME;
        case (item.request_code)
          ufu_pkg::RQ_GET_CUR:
            rdata = $unsigned((ch == ufu_pkg::CH_LEFT) ? chan_left : chan_right);
          ufu_pkg::RQ_GET_MIN: rdata = $unsigned(cfg.vol_min);
          ufu_pkg::RQ_GET_MAX: rdata = $unsigned(cfg.vol_max);
          default:             rdata = $unsigned(cfg.vol_res);
        endcase
      end else begin
        stall = 1'b1;
      end
    end else begin
      stall = 1'b1;
    end

    // Applied pair follows the stored state whenever it is driven
    if (drive) begin
      out_left_next  = muted_next ? cfg.vol_mute : chan_left_next;
      out_right_next = muted_next ? cfg.vol_mute : chan_right_next;
    end else begin
      out_left_next  = out_left;
      out_right_next = out_right;
    end
  end

  always_comb begin
    result.stall_res     = stall;
    result.reply_length  = rlen;
    result.reply_data    = rdata;
    result.apply_valid   = drive;
    result.applied_left  = out_left_next;
    result.applied_right = out_right_next;
  end

  // State update on each committed item
  always_ff @(posedge clk) begin
    if (rst) begin
      muted      <= 1'b1;
      chan_left  <= 16'sh0000;
      chan_right <= 16'sh0000;
      out_left   <= 16'sh0000;
      out_right  <= 16'sh0000;
    end else if (commit) begin
      muted      <= muted_next;
      chan_left  <= chan_left_next;
      chan_right <= chan_right_next;
      out_left   <= out_left_next;
      out_right  <= out_right_next;
    end
  end

endmodule

`default_nettype wire
